// ----- hw/rtl/cba_pkg.sv -----
// Shared types and constants of the contiguous block allocator.
// Beat structs for the request and response channels, codes and defaults.
// No dependencies.
`default_nettype none

package cba_pkg;

  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_ADDR_BITS   = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MEMORY_SIZE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY  = 2'd1;

  localparam logic [15:0] MEMORY_SIZE_RESET = 16'd1024;
  localparam logic        FIT_POLICY_RESET  = 1'b0;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_COMPACT = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NO_FIT   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_BAD_IDX  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_size;
    logic [5:0]  entry_select;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] region_start;
    logic [5:0]  region_slot;
    logic [6:0]  region_total;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/contiguous_block_allocator_core.sv -----
// Contiguous block allocator: address-ordered region table in one RAM.
// Depends on cba_pkg for beat types, request codes and status codes.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | cba_pkg::req_t
//   rsp     | out | rsp_valid/rsp_stall  | cba_pkg::rsp_t
//   cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request at a time. Allocate scans for a gap, shifts later entries up
// and inserts; free shifts later entries down; compact packs regions from 0;
// the region RAM (one read and one write per cycle) paces these steps.
// Reset clears the region count, not the RAM; entries at or above the count do not affect results.
// The response register holds a beat under rsp_stall; a finished request
// waits in its last state until that register is free.
`default_nettype none

module contiguous_block_allocator_core #(
  parameter int MAX_REGIONS = cba_pkg::DEF_MAX_REGIONS,
  parameter int ADDR_BITS   = cba_pkg::DEF_ADDR_BITS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                req_valid,
  output logic                               req_stall,
  input  wire cba_pkg::req_t                 req,
  output logic                               rsp_valid,
  input  wire                                rsp_stall,
  output cba_pkg::rsp_t                      rsp,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [cba_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire [cba_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IW = $clog2(MAX_REGIONS);
  localparam int UW = $clog2(MAX_REGIONS + 1);
  localparam int AW = ADDR_BITS;
  localparam int CW = (ADDR_BITS > 16) ? ADDR_BITS : 16;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_SHUP, S_INS, S_SHDN, S_COMP, S_DONE
  } state_t;

  state_t           state;
  logic [15:0]      memory_size;
  logic             fit_policy;
  logic [UW-1:0]    used;
  logic [UW-1:0]    k;
  logic [UW-1:0]    slot;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    where;
  logic [CW-1:0]    best;
  logic             found;
  logic [15:0]      size;
  logic [2:0]       res_status;
  logic [15:0]      res_start;
  logic [5:0]       res_slot;

  logic [2*AW-1:0]  mem [MAX_REGIONS];
  logic [2*AW-1:0]  rd_data;
  logic [UW-1:0]    rd_ptr;
  logic [UW-1:0]    wr_ptr;
  logic [2*AW-1:0]  wr_data;
  logic             wr_en;

  logic [AW-1:0]    ent_start;
  logic [AW-1:0]    ent_len;
  logic [CW-1:0]    limit_c;
  logic [CW-1:0]    pos_c;
  logic [CW-1:0]    gap_c;
  logic             take;
  logic [UW-1:0]    used_m1;
  logic [UW+5:0]    sel_w;
  logic [UW+5:0]    used_w;
  logic [UW+5:0]    sel_p1_w;
  logic [AW+15:0]   size_w;
  logic [AW+15:0]   where_w;
  logic [UW+5:0]    slot_w;
  logic [UW+6:0]    used_x;
  logic             rsp_free;

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign ent_start = rd_data[2*AW-1:AW];
  assign ent_len   = rd_data[AW-1:0];
  assign limit_c   = (state == S_LAST) ? CW'(memory_size) : CW'(ent_start);
  assign pos_c     = CW'(pos);
  assign gap_c     = (limit_c > pos_c) ? (limit_c - pos_c) : '0;
  assign take      = (CW'(size) <= gap_c) && (!found || (fit_policy && (gap_c < best)));

  assign used_m1  = used - UW'(1);
  assign sel_w    = (UW+6)'(req.entry_select);
  assign used_w   = (UW+6)'(used);
  assign sel_p1_w = sel_w + (UW+6)'(1);
  assign size_w   = (AW+16)'(size);
  assign where_w  = (AW+16)'(where);
  assign slot_w   = (UW+6)'(slot);
  assign used_x   = (UW+7)'(used);
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    rd_ptr  = '0;
    wr_ptr  = '0;
    wr_data = rd_data;
    wr_en   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.req_type == cba_pkg::REQ_FREE) begin
          rd_ptr = sel_p1_w[UW-1:0];
        end
      end
      S_SCAN: rd_ptr = k + UW'(1);
      S_LAST: rd_ptr = used_m1;
      S_SHUP: begin
        rd_ptr = k - UW'(1);
        wr_ptr = k + UW'(1);
        wr_en  = 1'b1;
      end
      S_INS: begin
        wr_ptr  = slot;
        wr_data = {where, size_w[AW-1:0]};
        wr_en   = 1'b1;
      end
      S_SHDN: begin
        rd_ptr = k + UW'(1);
        wr_ptr = k - UW'(1);
        wr_en  = 1'b1;
      end
      S_COMP: begin
        rd_ptr  = k + UW'(1);
        wr_ptr  = k;
        wr_data = {pos, ent_len};
        wr_en   = 1'b1;
      end
      default: rd_ptr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr[IW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      used        <= '0;
      memory_size <= cba_pkg::MEMORY_SIZE_RESET;
      fit_policy  <= cba_pkg::FIT_POLICY_RESET;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            size       <= req.request_size;
            res_start  <= '0;
            res_slot   <= '0;
            res_status <= cba_pkg::ST_OK;
            found      <= 1'b0;
            best       <= '0;
            pos        <= '0;
            k          <= '0;
            state      <= S_DONE;
            case (req.req_type)
              cba_pkg::REQ_ALLOC: begin
                if (used == UW'(MAX_REGIONS)) begin
                  res_status <= cba_pkg::ST_FULL;
                end else if (req.request_size == 16'd0) begin
                  res_status <= cba_pkg::ST_BAD_SIZE;
                end else begin
                  state <= (used == '0) ? S_LAST : S_SCAN;
                end
              end
              cba_pkg::REQ_FREE: begin
                if (used == '0) begin
                  res_status <= cba_pkg::ST_EMPTY;
                end else if (sel_w >= used_w) begin
                  res_status <= cba_pkg::ST_BAD_IDX;
                end else if (sel_p1_w == used_w) begin
                  used <= used_m1;
                end else begin
                  k     <= sel_p1_w[UW-1:0];
                  state <= S_SHDN;
                end
              end
              cba_pkg::REQ_COMPACT: begin
                if (used == '0) begin
                  res_status <= cba_pkg::ST_EMPTY;
                end else begin
                  state <= S_COMP;
                end
              end
              default: res_status <= cba_pkg::ST_OK;
            endcase
          end
        end
        S_SCAN: begin
          if (take) begin
            found <= 1'b1;
            slot  <= k;
            where <= pos;
            best  <= gap_c;
          end
          pos <= ent_start + ent_len;
          if (k == used_m1) begin
            state <= S_LAST;
          end else begin
            k <= k + UW'(1);
          end
        end
        S_LAST: begin
          if (!found && !take) begin
            res_status <= cba_pkg::ST_NO_FIT;
            state      <= S_DONE;
          end else begin
            if (take) begin
              slot  <= used;
              where <= pos;
              state <= S_INS;
            end else if (slot == used) begin
              state <= S_INS;
            end else begin
              k     <= used_m1;
              state <= S_SHUP;
            end
          end
        end
        S_SHUP: begin
          if (k == slot) begin
            state <= S_INS;
          end else begin
            k <= k - UW'(1);
          end
        end
        S_INS: begin
          used       <= used + UW'(1);
          res_status <= cba_pkg::ST_OK;
          res_start  <= where_w[15:0];
          res_slot   <= slot_w[5:0];
          state      <= S_DONE;
        end
        S_SHDN: begin
          if (k == used_m1) begin
            used  <= used_m1;
            state <= S_DONE;
          end else begin
            k <= k + UW'(1);
          end
        end
        S_COMP: begin
          pos <= pos + ent_len;
          if (k == used_m1) begin
            state <= S_DONE;
          end else begin
            k <= k + UW'(1);
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.region_start <= res_start;
            rsp.region_slot  <= res_slot;
            rsp.region_total <= used_x[6:0];
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_valid) begin
        if (cfg_index == cba_pkg::CFG_MEMORY_SIZE) begin
          memory_size <= cfg_data;
          used        <= '0;
        end else if (cfg_index == cba_pkg::CFG_FIT_POLICY) begin
          fit_policy <= cfg_data[0];
          used       <= '0;
        end
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(MAX_REGIONS))
    else $error("region count above table depth");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && !cfg_valid) |=> (used == $past(used) + UW'(1)))
    else $error("insert did not add one region");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (wr_ptr <= used))
    else $error("table write beyond region count");

  a_ok_on_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP) |-> (slot < used))
    else $error("shift up with insert slot at or past end");

endmodule

`default_nettype wire

// ----- sim/tb_contiguous_block_allocator_core.sv -----
// Testbench for contiguous_block_allocator_core: random and directed request beats
// are checked against a region-table tracker kept in the bench.
// Depends on cba_pkg and the core RTL.
`default_nettype none

module tb_contiguous_block_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [cba_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [cba_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int N_PHASES = 12;
  localparam int WATCHDOG_LIMIT = 3000;

  class region_tracker;
    logic [15:0] mem_size;
    bit best_fit;
    logic [15:0] starts [cba_pkg::DEF_MAX_REGIONS];
    logic [15:0] lens [cba_pkg::DEF_MAX_REGIONS];
    int unsigned used;
    cba_pkg::rsp_t due_rsp [$];
    int unsigned faults;
    int unsigned beat_no;

    function new();
      mem_size = cba_pkg::MEMORY_SIZE_RESET;
      best_fit = cba_pkg::FIT_POLICY_RESET;
      used = 0;
      faults = 0;
      beat_no = 0;
    endfunction

    function int unsigned outstanding();
      return due_rsp.size();
    endfunction

    function void report(string what);
      faults++;
      if (faults <= 10) $display("%s", what);
    endfunction

    function void note_config(logic [cba_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] data);
      if (idx == cba_pkg::CFG_MEMORY_SIZE) begin
        mem_size = data;
        used = 0;
      end else if (idx == cba_pkg::CFG_FIT_POLICY) begin
        best_fit = data[0];
        used = 0;
      end
    endfunction

    function void note_request(cba_pkg::req_t r);
      cba_pkg::rsp_t e;
      logic [15:0] pos, lim, gap, best_gap, where;
      int unsigned slot;
      bit found;
      e = '0;
      pos = '0;
      best_gap = '0;
      where = '0;
      slot = 0;
      found = 1'b0;
      case (r.req_type)
        cba_pkg::REQ_ALLOC: begin
          if (used >= cba_pkg::DEF_MAX_REGIONS) e.status = cba_pkg::ST_FULL;
          else if (r.request_size == 16'd0) e.status = cba_pkg::ST_BAD_SIZE;
          else begin
            for (int i = 0; i <= used; i++) begin
              lim = (i < used) ? starts[i] : mem_size;
              gap = (lim > pos) ? lim - pos : 16'd0;
              if (r.request_size <= gap && (!found || (best_fit && gap < best_gap))) begin
                found = 1'b1;
                slot = i;
                where = pos;
                best_gap = gap;
              end
              if (i < used) pos = starts[i] + lens[i];
            end
            if (!found) e.status = cba_pkg::ST_NO_FIT;
            else begin
              for (int i = used; i > slot; i--) begin
                starts[i] = starts[i-1];
                lens[i] = lens[i-1];
              end
              starts[slot] = where;
              lens[slot] = r.request_size;
              used++;
              e.status = cba_pkg::ST_OK;
              e.region_start = where;
              e.region_slot = 6'(slot);
            end
          end
        end
        cba_pkg::REQ_FREE: begin
          if (used == 0) e.status = cba_pkg::ST_EMPTY;
          else if (r.entry_select >= used) e.status = cba_pkg::ST_BAD_IDX;
          else begin
            used--;
            for (int i = r.entry_select; i < used; i++) begin
              starts[i] = starts[i+1];
              lens[i] = lens[i+1];
            end
            e.status = cba_pkg::ST_OK;
          end
        end
        cba_pkg::REQ_COMPACT: begin
          if (used == 0) e.status = cba_pkg::ST_EMPTY;
          else begin
            starts[0] = '0;
            for (int i = 1; i < used; i++) starts[i] = starts[i-1] + lens[i-1];
            e.status = cba_pkg::ST_OK;
          end
        end
        default: e.status = cba_pkg::ST_OK;
      endcase
      e.region_total = 7'(used);
      due_rsp.push_back(e);
    endfunction

    function void check_rsp(cba_pkg::rsp_t got);
      cba_pkg::rsp_t want;
      if (due_rsp.size() == 0) begin
        report($sformatf({"rsp beat %0d with nothing outstanding: ",
                          "st=%0d start=%0d slot=%0d total=%0d"},
                         beat_no, got.status, got.region_start, got.region_slot,
                         got.region_total));
        beat_no++;
        return;
      end
      want = due_rsp.pop_front();
      if (got.status !== want.status || got.region_start !== want.region_start ||
          got.region_slot !== want.region_slot || got.region_total !== want.region_total)
        report($sformatf({"rsp beat %0d: exp st=%0d start=%0d slot=%0d total=%0d, ",
                          "got st=%0d start=%0d slot=%0d total=%0d"}, beat_no,
                         want.status, want.region_start, want.region_slot, want.region_total,
                         got.status, got.region_start, got.region_slot, got.region_total));
      beat_no++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  cba_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  cba_pkg::rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cba_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  region_tracker tracker;
  bit steady = 1'b0;
  int unsigned burst_left = 0;
  int unsigned alloc_pct = 55;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned idle_cycles = 0;

  contiguous_block_allocator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 1) == 0);
      default: rsp_stall <= ((stall_left % 40) < 25);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_rsp(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_contiguous_block_allocator_core: errors");
        $finish;
      end
    end
  end

  function automatic cba_pkg::req_t make_req(logic [1:0] kind, logic [15:0] size,
                                             logic [5:0] sel);
    cba_pkg::req_t r;
    r.req_type = kind;
    r.request_size = size;
    r.entry_select = sel;
    return r;
  endfunction

  function automatic cba_pkg::req_t random_request();
    cba_pkg::req_t r;
    int unsigned roll, cap;
    r.request_size = 16'($urandom);
    r.entry_select = 6'($urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      r.req_type = cba_pkg::REQ_ALLOC;
      cap = tracker.mem_size / 48;
      if (cap == 0) cap = 1;
      roll = $urandom_range(0, 99);
      if (roll < 4) r.request_size = 16'd0;
      else if (roll < 12) r.request_size = 16'($urandom);
      else if (roll < 22 && tracker.mem_size != 0)
        r.request_size = 16'($urandom_range(1, tracker.mem_size));
      else r.request_size = 16'($urandom_range(1, cap));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        r.req_type = cba_pkg::REQ_FREE;
        if (tracker.used > 0 && $urandom_range(0, 9) != 0)
          r.entry_select = 6'($urandom_range(0, tracker.used - 1));
      end else if (roll < 95) r.req_type = cba_pkg::REQ_COMPACT;
      else r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send_item(input cba_pkg::req_t r);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    tracker.note_request(r);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else burst_left--;
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cba_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] mem_plan;
    bit fit_plan;
    int unsigned n_items;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: begin mem_plan = 16'hFFFF; fit_plan = 1'b0; end
          2: begin mem_plan = 16'hFFFF; fit_plan = 1'b1; end
          3: begin mem_plan = 16'd0; fit_plan = 1'b1; end
          4: begin mem_plan = 16'd1; fit_plan = 1'b0; end
          5: begin mem_plan = 16'd64; fit_plan = 1'b1; end
          6: begin mem_plan = 16'd1024; fit_plan = 1'b0; end
          7: begin mem_plan = 16'($urandom_range(2, 4000)); fit_plan = 1'b1; end
          8: begin mem_plan = 16'($urandom); fit_plan = 1'b0; end
          9: begin mem_plan = 16'd300; fit_plan = 1'b1; end
          10: begin mem_plan = 16'hFFFF; fit_plan = 1'b1; end
          default: begin mem_plan = 16'($urandom_range(1, 65535)); fit_plan = 1'b0; end
        endcase
        write_reg(cba_pkg::CFG_MEMORY_SIZE, mem_plan);
        write_reg(cba_pkg::CFG_FIT_POLICY, {15'($urandom), fit_plan});
      end
      steady = (p % 4 == 3);
      alloc_pct = (p % 3 == 1) ? 85 : 55;
      n_items = (p == 3) ? 30 : 105;

      if (p == 0) begin
        send_item(make_req(cba_pkg::REQ_COMPACT, 16'h0000, 6'd0));
        send_item(make_req(cba_pkg::REQ_FREE, 16'hFFFF, 6'd0));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd0, 6'd63));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'hFFFF, 6'd0));
        send_item(make_req(REQ_UNUSED, 16'hFFFF, 6'd63));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd100, 6'd0));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd200, 6'd0));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd300, 6'd0));
        send_item(make_req(cba_pkg::REQ_FREE, 16'd0, 6'd63));
        send_item(make_req(cba_pkg::REQ_FREE, 16'd0, 6'd3));
        send_item(make_req(cba_pkg::REQ_FREE, 16'd0, 6'd1));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd150, 6'd0));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd424, 6'd0));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd1, 6'd0));
        send_item(make_req(cba_pkg::REQ_FREE, 16'd0, 6'd0));
        send_item(make_req(cba_pkg::REQ_COMPACT, 16'h5555, 6'd42));
        send_item(make_req(cba_pkg::REQ_ALLOC, 16'd1024, 6'd21));
        send_item(make_req(REQ_UNUSED, 16'd0, 6'd0));
      end

      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 59) == 0) settle();
        // spare register indexes must leave the table alone
        if (p == 6 && k == 50) begin
          settle();
          write_reg(CFG_SPARE_A, 16'($urandom));
          write_reg(CFG_SPARE_B, 16'($urandom));
        end
        send_item(random_request());
      end
    end

    req_valid <= 1'b0;
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (tracker.faults == 0 && tracker.outstanding() == 0)
      $display("tb_contiguous_block_allocator_core: clean");
    else
      $display("tb_contiguous_block_allocator_core: errors");
    $finish;
  end

endmodule

`default_nettype wire
